[rtl/core/bol_pkg.sv]
// ----------------------------------------------------------------------------
// bol_pkg
// Shared types and codes for the bounded ordered list: field widths, operation
// and status codes, and the control word broadcast along the cell chain.
// ----------------------------------------------------------------------------
package bol_pkg;

    localparam int DATA_W       = 32;
    localparam int FUNC_W       = 3;
    localparam int STATUS_W     = 3;
    localparam int FILL_W       = 5;
    localparam int CAPACITY_DEF = 16;

    // operation codes on the func field
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_INSERT     = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DELETE     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READOUT    = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_ELEMENT  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd4;

    // per-cycle command to every cell
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_INS,
        CELL_DEL,
        CELL_ROT
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic [FUNC_W-1:0]         func;
        logic signed [DATA_W-1:0]  value;
    } t_cell_ctl;

endpackage

[rtl/core/bounded_ordered_list.sv]
// ----------------------------------------------------------------------------
// bounded_ordered_list
// Bounded list of signed 32-bit values kept in a chain of cells, with push,
// ordered insert, delete and in-order readout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries func and value; output
//   channel (o_out_valid / i_out_ready) carries status, element, fill, last.
//   Push front, push back, ordered insert and delete give one result each,
//   registered in the update cycle: every cell compares against the value
//   in the transfer cycle itself, and the next cycle resolves the first
//   hit along the chain and shifts. A new item is taken only once the
//   result of the last one is registered and while the receiver keeps up.
//   A readout gives one result per stored element, one a cycle while the
//   receiver keeps up, by rotating the occupied cells left and showing
//   the head cell; after the last element the list is back in its
//   original order. Readout of an empty list gives one empty-list result.
//   Reset empties the list at once (no clearing pass) and drops any pending
//   result. When the receiver stalls, the result register holds, readout
//   rotation pauses, and no new item is accepted.
// ----------------------------------------------------------------------------
module bounded_ordered_list
    import bol_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [FUNC_W-1:0]          i_func,
    input  logic signed [DATA_W-1:0]   i_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [DATA_W-1:0]   o_element,
    output logic [FILL_W-1:0]          o_fill,
    output logic                       o_last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_READ
    } t_state;

    t_state                   r_state;
    logic [FUNC_W-1:0]        r_func;
    logic signed [DATA_W-1:0] r_value;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [CNT_W-1:0]         r_rd_idx;
    logic                     r_out_valid;
    logic [STATUS_W-1:0]      r_out_status;
    logic signed [DATA_W-1:0] r_out_element;
    logic [FILL_W-1:0]        r_out_fill;
    logic                     r_out_last;

    t_cell_ctl                ctl;
    logic                     out_free;
    logic                     in_xfer;
    logic                     full;
    logic                     found;
    logic                     rd_last;
    logic [STATUS_W-1:0]      cmp_status;
    logic signed [DATA_W-1:0] cell_val  [CAPACITY];
    logic                     hit_chain [CAPACITY+1];

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign full       = r_count == CAP_CNT;
    assign found      = hit_chain[CAPACITY];
    assign rd_last    = r_rd_idx == (r_count - CNT_W'(1));

    // command broadcast to the chain
    always_comb begin
        ctl.op    = CELL_HOLD;
        ctl.func  = r_func;
        ctl.value = r_value;
        unique case (r_state)
            ST_IDLE: begin
                ctl.func  = i_func;
                ctl.value = i_value;
                if (in_xfer) ctl.op = CELL_CMP;
            end
            ST_CMP: begin
                if (r_func <= FUNC_INSERT && !full) ctl.op = CELL_INS;
                else if (r_func == FUNC_DELETE) ctl.op = CELL_DEL;
            end
            ST_READ: begin
                if (out_free) ctl.op = CELL_ROT;
            end
            default: ;
        endcase
    end

    // occupancy after the update cycle
    always_comb begin
        n_count = r_count;
        if (ctl.op == CELL_INS) n_count = r_count + CNT_W'(1);
        else if (ctl.op == CELL_DEL && found) n_count = r_count - CNT_W'(1);
    end

    // status of a single-result operation, settled in the update cycle
    always_comb begin
        cmp_status = STATUS_DONE;
        if (r_func <= FUNC_INSERT) begin
            if (full) cmp_status = STATUS_FULL;
        end else if (r_func == FUNC_DELETE) begin
            if (!found) cmp_status = STATUS_NOTFOUND;
        end else if (r_func == FUNC_READOUT) begin
            if (r_count == '0) cmp_status = STATUS_EMPTY;
        end
    end

    // cell chain
    assign hit_chain[0] = 1'b0;
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        bol_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_count     (r_count),
            .i_left_val  (cell_val[(g == 0) ? 0 : g - 1]),
            .i_right_val (cell_val[(g == CAPACITY - 1) ? g : g + 1]),
            .i_head_val  (cell_val[0]),
            .i_before    (hit_chain[g]),
            .o_before    (hit_chain[g + 1]),
            .o_val       (cell_val[g])
        );
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            unique case (r_state)
                ST_IDLE: begin
                    if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
                    if (in_xfer) begin
                        r_func  <= i_func;
                        r_value <= i_value;
                        r_state <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    r_out_status  <= cmp_status;
                    r_out_element <= '0;
                    r_out_fill    <= FILL_W'(n_count);
                    r_out_last    <= 1'b1;
                    if (r_func == FUNC_READOUT && r_count != '0) begin
                        r_rd_idx <= '0;
                        r_state  <= ST_READ;
                    end else begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_READ: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_status  <= STATUS_ELEMENT;
                        r_out_element <= cell_val[0];
                        r_out_fill    <= FILL_W'(r_count);
                        r_out_last    <= rd_last;
                        r_rd_idx      <= r_rd_idx + CNT_W'(1);
                        if (rd_last) r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_element   = r_out_element;
    assign o_fill      = r_out_fill;
    assign o_last      = r_out_last;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("occupancy above capacity");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP && r_func <= FUNC_INSERT && full) |=> $stable(r_count))
        else $error("insert into full list changed occupancy");

    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_count != '0 && r_rd_idx < r_count))
        else $error("readout index out of range");

    a_element_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == STATUS_ELEMENT) |-> (r_count != '0))
        else $error("element result from empty list");
`endif

endmodule

[rtl/core/bol_cell.sv]
// ----------------------------------------------------------------------------
// bol_cell
// One slot of the list. Registers a match flag on compare, then shifts toward
// its neighbors or loads the broadcast value on update; rotates on readout.
// ----------------------------------------------------------------------------
module bol_cell
    import bol_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic [CNT_W-1:0]         i_count,
    input  logic signed [DATA_W-1:0] i_left_val,
    input  logic signed [DATA_W-1:0] i_right_val,
    input  logic signed [DATA_W-1:0] i_head_val,
    input  logic                     i_before,
    output logic                     o_before,
    output logic signed [DATA_W-1:0] o_val
);

    localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

    logic signed [DATA_W-1:0] r_val;
    logic                     r_match;
    logic                     valid;
    logic                     is_tail;
    logic                     match_now;

    assign valid   = MY_IDX < i_count;
    assign is_tail = MY_NEXT == i_count;

    // where this cell stands relative to the operation's target slot
    always_comb begin
        case (i_ctl.func)
            FUNC_PUSH_FRONT: match_now = 1'b1;
            FUNC_PUSH_BACK:  match_now = !valid;
            FUNC_INSERT:     match_now = !valid || (r_val > i_ctl.value);
            FUNC_DELETE:     match_now = valid && (r_val == i_ctl.value);
            default:         match_now = 1'b0;
        endcase
    end

    // first-match chain: anything upstream already hit
    assign o_before = i_before | r_match;
    assign o_val    = r_val;

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            CELL_CMP: r_match <= match_now;
            CELL_INS: begin
                if (i_before) r_val <= i_left_val;
                else if (r_match) r_val <= i_ctl.value;
            end
            CELL_DEL: begin
                if (i_before || r_match) r_val <= i_right_val;
            end
            CELL_ROT: begin
                if (is_tail) r_val <= i_head_val;
                else if (valid) r_val <= i_right_val;
            end
            default: ;
        endcase
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bounded_ordered_list. A queue of list operations is
// built up front: a directed opening, then random fill, drain and mixed
// phases. A clocked driver sends the operations. It updates a shadow copy of
// the list on every input transfer and queues the results that the list owes.
// A clocked monitor checks each output transfer field by field. Both sides
// idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import bol_pkg::*;

    localparam int LIST_DEPTH   = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 250;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 800000;

    typedef struct {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] value;
        bit                       hold;   // wait for all results before sending
    } t_list_op;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] element;
        logic [FILL_W-1:0]        fill;
        logic                     last;
    } t_list_result;

    // DUT ports
    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_ready;
    logic [FUNC_W-1:0]        i_func      = '0;
    logic signed [DATA_W-1:0] i_value     = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [STATUS_W-1:0]      o_status;
    logic signed [DATA_W-1:0] o_element;
    logic [FILL_W-1:0]        o_fill;
    logic                     o_last;

    // operations still to send, and results the list owes
    t_list_op     list_ops_todo[$];
    t_list_result list_results_due[$];

    // shadow copy of the list contents
    logic signed [DATA_W-1:0] shadow_cells[LIST_DEPTH];
    int                       shadow_count = 0;

    // multiset of stored values, tracked while the operations are built
    logic signed [DATA_W-1:0] plan_bag[$];

    int error_count   = 0;
    int ops_sent      = 0;
    int results_seen  = 0;
    int readouts_done = 0;
    int full_drops    = 0;
    int misses        = 0;
    int holds_done    = 0;
    int cycle_count   = 0;

    bounded_ordered_list dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_element   (o_element),
        .o_fill      (o_fill),
        .o_last      (o_last)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        error_count++;
    endtask

    function automatic void owe_result(input logic [STATUS_W-1:0] status,
                                       input logic signed [DATA_W-1:0] element,
                                       input logic last);
        t_list_result r;
        r.status  = status;
        r.element = element;
        r.fill    = shadow_count[FILL_W-1:0];
        r.last    = last;
        list_results_due.push_back(r);
    endfunction

    // apply one operation to the shadow list and queue what it returns
    function automatic void apply_list_op(input logic [FUNC_W-1:0] func,
                                          input logic signed [DATA_W-1:0] v);
        int pos;
        int hit;
        pos = shadow_count;
        hit = -1;
        case (func)
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK, FUNC_INSERT: begin
                if (shadow_count >= LIST_DEPTH) begin
                    full_drops++;
                    owe_result(STATUS_FULL, '0, 1'b1);
                end else begin
                    if (func == FUNC_PUSH_FRONT) begin
                        pos = 0;
                    end else if (func == FUNC_INSERT) begin
                        // goes in front of the first strictly greater value
                        for (int i = 0; i < shadow_count; i++) begin
                            if (shadow_cells[i] > v) begin
                                pos = i;
                                break;
                            end
                        end
                    end
                    for (int i = shadow_count; i > pos; i--)
                        shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[pos] = v;
                    shadow_count++;
                    owe_result(STATUS_DONE, '0, 1'b1);
                end
            end
            FUNC_DELETE: begin
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_cells[i] == v) begin
                        hit = i;
                        break;
                    end
                end
                if (hit < 0) begin
                    misses++;
                    owe_result(STATUS_NOTFOUND, '0, 1'b1);
                end else begin
                    for (int i = hit; i + 1 < shadow_count; i++)
                        shadow_cells[i] = shadow_cells[i+1];
                    shadow_count--;
                    owe_result(STATUS_DONE, '0, 1'b1);
                end
            end
            FUNC_READOUT: begin
                readouts_done++;
                if (shadow_count == 0) begin
                    owe_result(STATUS_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < shadow_count; i++)
                        owe_result(STATUS_ELEMENT, shadow_cells[i], i + 1 == shadow_count);
                end
            end
            default: begin
                // unused codes leave the list alone
                owe_result(STATUS_DONE, '0, 1'b1);
            end
        endcase
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int next_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [DATA_W-1:0] rnd_value();
        int small_val;
        case ($urandom_range(0, 7))
            0, 1, 2: begin
                // narrow range, so equal values are common
                small_val = $urandom_range(0, 16);
                return small_val - 8;
            end
            3: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return '0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // queue one operation and track what the list will then hold
    function automatic void plan_op(input logic [FUNC_W-1:0] func,
                                    input logic signed [DATA_W-1:0] v,
                                    input bit hold);
        t_list_op op;
        op.func  = func;
        op.value = v;
        op.hold  = hold;
        list_ops_todo.push_back(op);
        if (func <= FUNC_INSERT && plan_bag.size() < LIST_DEPTH) begin
            plan_bag.push_back(v);
        end else if (func == FUNC_DELETE) begin
            for (int i = 0; i < plan_bag.size(); i++) begin
                if (plan_bag[i] == v) begin
                    plan_bag.delete(i);
                    break;
                end
            end
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] delete_target();
        if (plan_bag.size() > 0 && $urandom_range(0, 3) != 0)
            return plan_bag[$urandom_range(0, plan_bag.size() - 1)];
        return rnd_value();
    endfunction

    // driver: sends queued operations, updates the shadow list on each transfer
    int driver_gap  = 0;
    int driver_calm = 0;
    always @(posedge i_clk) begin : driver_proc
        t_list_op op;
        bit       busy;
        bit       calm;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            busy = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                apply_list_op(i_func, i_value);
                ops_sent++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (driver_gap > 0) begin
                    driver_gap--;
                    i_in_valid <= 1'b0;
                end else if (list_ops_todo.size() > 0 &&
                             (!list_ops_todo[0].hold || list_results_due.size() == 0)) begin
                    op = list_ops_todo.pop_front();
                    if (op.hold)
                        holds_done++;
                    i_func     <= op.func;
                    i_value    <= op.value;
                    i_in_valid <= 1'b1;
                    // occasional stretch with back-to-back items
                    calm = driver_calm > 0;
                    if (calm)
                        driver_calm--;
                    else if ($urandom_range(0, 39) == 0)
                        driver_calm = $urandom_range(20, 40);
                    driver_gap = next_gap(calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each output transfer, stalls the result side at random
    int monitor_stall = 0;
    int monitor_calm  = 0;
    always @(posedge i_clk) begin : monitor_proc
        t_list_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (list_results_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status %0d element %0d",
                                              o_status, o_element));
                end else begin
                    want = list_results_due.pop_front();
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  o_status, want.status));
                    if (o_element !== want.element)
                        report_mismatch($sformatf("element %0d, want %0d",
                                                  o_element, want.element));
                    if (o_fill !== want.fill)
                        report_mismatch($sformatf("fill %0d, want %0d",
                                                  o_fill, want.fill));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b",
                                                  o_last, want.last));
                end
                results_seen++;
            end
            if (monitor_stall > 0) begin
                monitor_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (monitor_calm > 0)
                    monitor_calm--;
                else if ($urandom_range(0, 99) == 0)
                    monitor_calm = $urandom_range(40, 80);
                else if ($urandom_range(0, 3) == 0)
                    monitor_stall = next_gap(1'b0);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin : limit_proc
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, list_results_due.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // build the operation list, release reset, wait for the drain
    initial begin : stimulus_proc
        int  planned;
        int  n;
        int  kind;
        int  r;
        bit  first_phase;
        // directed opening: empty cases and unused codes first
        plan_op(FUNC_READOUT, '0, 1'b0);
        plan_op(FUNC_DELETE, 32'sd5, 1'b0);
        plan_op(3'd5, 32'sh7fff_ffff, 1'b0);
        plan_op(3'd6, 32'sh8000_0000, 1'b0);
        plan_op(3'd7, -1, 1'b0);
        // extremes, then equal values go after their twins
        plan_op(FUNC_PUSH_FRONT, 32'sh7fff_ffff, 1'b0);
        plan_op(FUNC_PUSH_BACK, 32'sh8000_0000, 1'b0);
        plan_op(FUNC_INSERT, 32'sd0, 1'b0);
        plan_op(FUNC_INSERT, 32'sd0, 1'b0);
        plan_op(FUNC_INSERT, -1, 1'b0);
        plan_op(FUNC_READOUT, '0, 1'b0);
        // first of two equal values, then the tail element
        plan_op(FUNC_DELETE, 32'sd0, 1'b0);
        plan_op(FUNC_DELETE, 32'sh8000_0000, 1'b0);
        plan_op(FUNC_DELETE, 32'sd12345, 1'b0);
        plan_op(FUNC_PUSH_BACK, 32'sd7, 1'b0);
        plan_op(FUNC_READOUT, '0, 1'b1);

        // random phases: fill to capacity or past it, delete at least as often as values are stored, or a mix
        planned = 0;
        first_phase = 1'b1;
        while (planned < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind <= 2) begin
                n = LIST_DEPTH - plan_bag.size() + $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                    plan_op(FUNC_W'($urandom_range(0, 2)), rnd_value(),
                            i == 0 && (first_phase || $urandom_range(0, 4) == 0));
                plan_op(FUNC_READOUT, $urandom, 1'b0);
                planned += n + 1;
            end else if (kind <= 4) begin
                n = plan_bag.size() + $urandom_range(0, 2);
                for (int i = 0; i < n; i++)
                    plan_op(FUNC_DELETE, delete_target(),
                            i == 0 && (first_phase || $urandom_range(0, 4) == 0));
                plan_op(FUNC_READOUT, $urandom, 1'b0);
                planned += n + 1;
            end else begin
                for (int i = 0; i < 8; i++) begin
                    r = $urandom_range(0, 19);
                    if (r < 9)
                        plan_op(FUNC_W'($urandom_range(0, 2)), rnd_value(), 1'b0);
                    else if (r < 14)
                        plan_op(FUNC_DELETE, delete_target(), 1'b0);
                    else if (r < 17)
                        plan_op(FUNC_READOUT, $urandom, 1'b0);
                    else
                        plan_op(FUNC_W'($urandom_range(5, 7)), $urandom, 1'b0);
                end
                planned += 8;
            end
            first_phase = 1'b0;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (list_ops_todo.size() > 0 || i_in_valid || list_results_due.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (list_results_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", list_results_due.size()));

        $display("covered %0d operations: %0d readouts, %0d full drops, %0d misses",
                 ops_sent, readouts_done, full_drops, misses);
        $display("checked %0d results in %0d cycles, %0d quiet-list pauses",
                 results_seen, cycle_count, holds_done);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

[bounded_ordered_list.f]
rtl/core/bol_pkg.sv
rtl/core/bol_cell.sv
rtl/core/bounded_ordered_list.sv
verif/testbench.sv
